// File: sv/snfcs_pkg.sv
// ----------------------------------------------------------------------------
// snfcs_pkg
// Shared codes and types of the SPI NOR flash command sequencer.
// ----------------------------------------------------------------------------
package snfcs_pkg;

  localparam int PAGE_BYTES_DEF = 256;
  localparam logic [7:0] RDID_OPCODE = 8'h9F;
  localparam int MAX_RES = 4;

  localparam logic [2:0] CMD_READ    = 3'd0;
  localparam logic [2:0] CMD_WRITE   = 3'd1;
  localparam logic [2:0] CMD_ERASE   = 3'd2;
  localparam logic [2:0] CMD_ID      = 3'd3;
  localparam logic [2:0] CMD_PAYLOAD = 3'd4;
  localparam logic [2:0] CMD_REPLY   = 3'd5;

  localparam logic [2:0] K_SEND    = 3'd0;
  localparam logic [2:0] K_RELEASE = 3'd1;
  localparam logic [2:0] K_READ    = 3'd2;
  localparam logic [2:0] K_ID      = 3'd3;
  localparam logic [2:0] K_DONE    = 3'd4;

  localparam logic [2:0] REG_PROGRAM = 3'd0;
  localparam logic [2:0] REG_READ    = 3'd1;
  localparam logic [2:0] REG_ENABLE  = 3'd2;
  localparam logic [2:0] REG_STATUS  = 3'd3;
  localparam logic [2:0] REG_ERASE   = 3'd4;
  localparam logic [2:0] REG_FILLER  = 3'd5;
  localparam logic [2:0] REG_BUSY    = 3'd6;
  localparam logic [2:0] REG_EXP_ID  = 3'd7;

  typedef enum logic [1:0] {OP_READ, OP_WRITE, OP_ERASE, OP_ID} op_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [23:0] value;
    logic        id_match;
  } res_t;

  typedef struct packed {
    logic [2:0]            cnt;
    res_t [MAX_RES-1:0]    r;
  } grp_t;

endpackage

// File: sv/snfcs_front.sv
// ----------------------------------------------------------------------------
// snfcs_front
// Accepts items, runs the sequencer state and builds the result group.
// PAGE_BYTES must be a power of two.
// ----------------------------------------------------------------------------
module snfcs_front import snfcs_pkg::*; #(
  parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic [2:0]  cmd,
  input  logic [23:0] addr,
  input  logic [15:0] len,
  input  logic [7:0]  dbyte,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_wdata,
  output grp_t        grp,
  output logic        push
);

  localparam int CW = $clog2(PAGE_BYTES + 1);
  localparam int AW = $clog2(PAGE_BYTES);

  typedef enum logic [3:0] {
    PH_IDLE, PH_WEN, PH_HDR, PH_RDATA, PH_PAYLOAD, PH_POLLCMD, PH_POLL, PH_ID
  } phase_t;

  phase_t      phase_r, phase_nxt;
  op_t         op_r, op_nxt;
  logic [23:0] addr_r, addr_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [CW-1:0] chunk_r, chunk_nxt;
  logic [1:0]  bidx_r, bidx_nxt;
  logic [23:0] id_r, id_nxt;
  logic        await_r, await_nxt;

  logic [7:0]  prog_r, rd_r, en_r, st_r, er_r, fill_r, busy_r;
  logic [23:0] exp_r;

  function automatic logic [CW-1:0] chunk_of(input logic [23:0] a, input logic [15:0] r);
    logic [CW-1:0] room;
    room = CW'(PAGE_BYTES) - CW'(a[AW-1:0]);
    return (r < 16'(room)) ? r[CW-1:0] : room;
  endfunction

  always_comb begin
    logic [2:0] n;
    logic [CW-1:0] c;
    phase_nxt = phase_r; op_nxt = op_r; addr_nxt = addr_r; rem_nxt = rem_r;
    chunk_nxt = chunk_r; bidx_nxt = bidx_r; id_nxt = id_r; await_nxt = await_r;
    grp = '0;
    n = '0;
    c = '0;
    if (cmd <= CMD_ID) begin
      if (phase_r == PH_IDLE) begin
        op_nxt = op_t'(cmd[1:0]);
        addr_nxt = addr; rem_nxt = len; bidx_nxt = '0;
        case (cmd)
          CMD_READ: begin
            phase_nxt = PH_HDR; await_nxt = 1'b1;
            grp.r[n[1:0]] = '{K_SEND, {16'd0, rd_r}, 1'b0}; n = n + 3'd1;
          end
          CMD_WRITE: begin
            if (len == 16'd0) begin
              grp.r[n[1:0]] = '{K_DONE, 24'd0, 1'b0}; n = n + 3'd1;
            end else begin
              chunk_nxt = chunk_of(addr, len); phase_nxt = PH_WEN; await_nxt = 1'b1;
              grp.r[n[1:0]] = '{K_SEND, {16'd0, en_r}, 1'b0}; n = n + 3'd1;
            end
          end
          CMD_ERASE: begin
            rem_nxt = '0; phase_nxt = PH_WEN; await_nxt = 1'b1;
            grp.r[n[1:0]] = '{K_SEND, {16'd0, en_r}, 1'b0}; n = n + 3'd1;
          end
          default: begin
            id_nxt = '0; phase_nxt = PH_ID; await_nxt = 1'b1;
            grp.r[n[1:0]] = '{K_SEND, {16'd0, RDID_OPCODE}, 1'b0}; n = n + 3'd1;
          end
        endcase
      end
    end else if (cmd == CMD_PAYLOAD) begin
      if (phase_r == PH_PAYLOAD && !await_r) begin
        await_nxt = 1'b1;
        grp.r[n[1:0]] = '{K_SEND, {16'd0, dbyte}, 1'b0}; n = n + 3'd1;
      end
    end else if (cmd == CMD_REPLY && await_r) begin
      await_nxt = 1'b0;
      case (phase_r)
        PH_WEN: begin
          grp.r[n[1:0]] = '{K_RELEASE, 24'd0, 1'b0}; n = n + 3'd1;
          phase_nxt = PH_HDR; bidx_nxt = '0; await_nxt = 1'b1;
          grp.r[n[1:0]] = '{K_SEND, {16'd0, (op_r == OP_WRITE) ? prog_r : er_r}, 1'b0};
          n = n + 3'd1;
        end
        PH_HDR: begin
          if (bidx_r != 2'd3) begin
            bidx_nxt = bidx_r + 2'd1; await_nxt = 1'b1;
            case (bidx_r)
              2'd0:    grp.r[n[1:0]] = '{K_SEND, {16'd0, addr_r[23:16]}, 1'b0};
              2'd1:    grp.r[n[1:0]] = '{K_SEND, {16'd0, addr_r[15:8]}, 1'b0};
              default: grp.r[n[1:0]] = '{K_SEND, {16'd0, addr_r[7:0]}, 1'b0};
            endcase
            n = n + 3'd1;
          end else if (op_r == OP_READ) begin
            if (rem_r == 16'd0) begin
              grp.r[n[1:0]] = '{K_RELEASE, 24'd0, 1'b0}; n = n + 3'd1;
              grp.r[n[1:0]] = '{K_DONE, 24'd0, 1'b0}; n = n + 3'd1;
              phase_nxt = PH_IDLE;
            end else begin
              phase_nxt = PH_RDATA; await_nxt = 1'b1;
              grp.r[n[1:0]] = '{K_SEND, {16'd0, fill_r}, 1'b0}; n = n + 3'd1;
            end
          end else if (op_r == OP_WRITE) begin
            phase_nxt = PH_PAYLOAD;
          end else begin
            grp.r[n[1:0]] = '{K_RELEASE, 24'd0, 1'b0}; n = n + 3'd1;
            phase_nxt = PH_POLLCMD; await_nxt = 1'b1;
            grp.r[n[1:0]] = '{K_SEND, {16'd0, st_r}, 1'b0}; n = n + 3'd1;
          end
        end
        PH_RDATA: begin
          grp.r[n[1:0]] = '{K_READ, {16'd0, dbyte}, 1'b0}; n = n + 3'd1;
          rem_nxt = rem_r - 16'd1;
          if (rem_nxt != 16'd0) begin
            await_nxt = 1'b1;
            grp.r[n[1:0]] = '{K_SEND, {16'd0, fill_r}, 1'b0}; n = n + 3'd1;
          end else begin
            grp.r[n[1:0]] = '{K_RELEASE, 24'd0, 1'b0}; n = n + 3'd1;
            grp.r[n[1:0]] = '{K_DONE, 24'd0, 1'b0}; n = n + 3'd1;
            phase_nxt = PH_IDLE;
          end
        end
        PH_PAYLOAD: begin
          rem_nxt = rem_r - 16'd1;
          addr_nxt = addr_r + 24'd1;
          c = (chunk_r != '0) ? chunk_r - CW'(1) : chunk_r;
          chunk_nxt = c;
          if (c == '0) begin
            grp.r[n[1:0]] = '{K_RELEASE, 24'd0, 1'b0}; n = n + 3'd1;
            phase_nxt = PH_POLLCMD; await_nxt = 1'b1;
            grp.r[n[1:0]] = '{K_SEND, {16'd0, st_r}, 1'b0}; n = n + 3'd1;
          end
        end
        PH_POLLCMD: begin
          phase_nxt = PH_POLL; await_nxt = 1'b1;
          grp.r[n[1:0]] = '{K_SEND, {16'd0, fill_r}, 1'b0}; n = n + 3'd1;
        end
        PH_POLL: begin
          if ((dbyte & busy_r) != 8'd0) begin
            await_nxt = 1'b1;
            grp.r[n[1:0]] = '{K_SEND, {16'd0, fill_r}, 1'b0}; n = n + 3'd1;
          end else begin
            grp.r[n[1:0]] = '{K_RELEASE, 24'd0, 1'b0}; n = n + 3'd1;
            if (op_r == OP_WRITE && rem_r != 16'd0) begin
              chunk_nxt = chunk_of(addr_r, rem_r); phase_nxt = PH_WEN; await_nxt = 1'b1;
              grp.r[n[1:0]] = '{K_SEND, {16'd0, en_r}, 1'b0}; n = n + 3'd1;
            end else begin
              grp.r[n[1:0]] = '{K_DONE, 24'd0, 1'b0}; n = n + 3'd1;
              phase_nxt = PH_IDLE;
            end
          end
        end
        PH_ID: begin
          if (bidx_r != 2'd0) id_nxt = {id_r[15:0], dbyte};
          if (bidx_r != 2'd3) begin
            bidx_nxt = bidx_r + 2'd1; await_nxt = 1'b1;
            grp.r[n[1:0]] = '{K_SEND, {16'd0, fill_r}, 1'b0}; n = n + 3'd1;
          end else begin
            grp.r[n[1:0]] = '{K_RELEASE, 24'd0, 1'b0}; n = n + 3'd1;
            grp.r[n[1:0]] = '{K_ID, id_nxt, id_nxt == exp_r}; n = n + 3'd1;
            grp.r[n[1:0]] = '{K_DONE, 24'd0, 1'b0}; n = n + 3'd1;
            phase_nxt = PH_IDLE;
          end
        end
        default: ;
      endcase
    end
    grp.cnt = n;
  end

  assign push = accept && (grp.cnt != 3'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE; op_r <= OP_READ; addr_r <= '0; rem_r <= '0;
      chunk_r <= '0; bidx_r <= '0; id_r <= '0; await_r <= 1'b0;
      prog_r <= 8'h02; rd_r <= 8'h03; en_r <= 8'h06; st_r <= 8'h05;
      er_r <= 8'h20; fill_r <= 8'hFF; busy_r <= 8'h01; exp_r <= '0;
    end else begin
      if (accept) begin
        phase_r <= phase_nxt; op_r <= op_nxt; addr_r <= addr_nxt; rem_r <= rem_nxt;
        chunk_r <= chunk_nxt; bidx_r <= bidx_nxt; id_r <= id_nxt; await_r <= await_nxt;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_PROGRAM: prog_r <= cfg_wdata[7:0];
          REG_READ:    rd_r   <= cfg_wdata[7:0];
          REG_ENABLE:  en_r   <= cfg_wdata[7:0];
          REG_STATUS:  st_r   <= cfg_wdata[7:0];
          REG_ERASE:   er_r   <= cfg_wdata[7:0];
          REG_FILLER:  fill_r <= cfg_wdata[7:0];
          REG_BUSY:    busy_r <= cfg_wdata[7:0];
          REG_EXP_ID:  exp_r  <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

endmodule

// File: sv/snfcs_queue.sv
// ----------------------------------------------------------------------------
// snfcs_queue
// Two-entry queue of result groups between front and back.
// ----------------------------------------------------------------------------
module snfcs_queue import snfcs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  grp_t din,
  input  logic pop,
  output grp_t head,
  output logic empty,
  output logic full
);

  grp_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign empty = (cnt_r == 2'd0);
  assign full  = (cnt_r == 2'd2);
  assign head  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// File: sv/snfcs_back.sv
// ----------------------------------------------------------------------------
// snfcs_back
// Sends the results of the head group one per transaction.
// ----------------------------------------------------------------------------
module snfcs_back import snfcs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  grp_t        head,
  input  logic        empty,
  input  logic        out_tready,
  output logic        out_tvalid,
  output logic [31:0] out_tdata,
  output logic [2:0]  out_tuser,
  output logic        out_tlast,
  output logic        pop
);

  logic [1:0] idx_r;
  res_t       cur;

  assign cur        = head.r[idx_r];
  assign out_tvalid = !empty;
  assign out_tlast  = ({1'b0, idx_r} == head.cnt - 3'd1);
  assign out_tdata  = {7'd0, cur.id_match, cur.value};
  assign out_tuser  = cur.kind;
  assign pop        = out_tvalid && out_tready && out_tlast;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (out_tvalid && out_tready) begin
      idx_r <= out_tlast ? 2'd0 : idx_r + 2'd1;
    end
  end

endmodule

// File: sv/spi_nor_flash_command_sequencer_core.sv
// ----------------------------------------------------------------------------
// spi_nor_flash_command_sequencer_core
// SPI NOR flash sequencer: requests and flash bytes in, SPI byte actions out.
//
// channel  direction  tdata                                tuser
// in_      slave      address, length, data_byte          command
// out_     master     value, id_match                      kind
// cfg_     write      register index and data              -
//
// One item is taken per cycle while the group queue has room; its results
// (up to three) leave one per cycle while the output is ready, once the
// group has reached the head of the queue.
// Reset is synchronous and restores the register defaults.
// A stalled output holds the queue; input stalls only when both entries fill.
// ----------------------------------------------------------------------------
module spi_nor_flash_command_sequencer_core import snfcs_pkg::*; #(
  parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // address[23:0], length[39:24], data_byte[47:40]
  input  logic [2:0]  in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // value[23:0], id_match[24]
  output logic [2:0]  out_tuser,  // kind
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_wdata
);

  grp_t grp, head;
  logic push, pop, empty, full, accept;

  assign in_tready = !full;
  assign accept    = in_tvalid && in_tready;

  snfcs_front #(.PAGE_BYTES(PAGE_BYTES)) u_front (
    .clk, .rst_n, .accept,
    .cmd(in_tuser), .addr(in_tdata[23:0]), .len(in_tdata[39:24]), .dbyte(in_tdata[47:40]),
    .cfg_we, .cfg_index, .cfg_wdata, .grp, .push
  );

  snfcs_queue u_queue (
    .clk, .rst_n, .push, .din(grp), .pop, .head, .empty, .full
  );

  snfcs_back u_back (
    .clk, .rst_n, .head, .empty, .out_tready, .out_tvalid, .out_tdata,
    .out_tuser, .out_tlast, .pop
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !accept) else $error("push into full queue");
  a_grp_count: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (grp.cnt <= 3'd4)) else $error("group too large");
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty) else $error("pop from empty queue");

endmodule
